@@ sv/focuser_command_framer_unit_assert.svh @@
// Assertion macros for the focuser command framer.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef FOCUSER_COMMAND_FRAMER_UNIT_ASSERT_SVH
`define FOCUSER_COMMAND_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/fcf_pkg.sv @@
// Shared types and constants for the focuser command framer.
// Used by fcf_frame, fcf_reply and the top level; depends on nothing.
`default_nettype none

package fcf_pkg;

  localparam logic [3:0] CMD_GET_POS    = 4'h1;
  localparam logic [3:0] CMD_SET_TARGET = 4'h2;
  localparam logic [3:0] CMD_HALT       = 4'h3;
  localparam logic [3:0] CMD_SET_COEFF  = 4'h4;
  localparam logic [3:0] CMD_GET_CONFIG = 4'h5;
  localparam logic [3:0] CMD_SET_CONFIG = 4'h6;
  localparam logic [3:0] CMD_SET_POS    = 4'h7;
  localparam logic [3:0] CMD_GET_HOME   = 4'h8;
  localparam logic [3:0] CMD_SET_VEL    = 4'h9;
  localparam logic [3:0] CMD_GET_TEMP   = 4'hA;
  localparam logic [3:0] CMD_GET_MOTION = 4'hB;

  localparam logic [7:0] HDR_GET_POS    = 8'h21;
  localparam logic [7:0] HDR_SET_TARGET = 8'h22;
  localparam logic [7:0] HDR_HALT       = 8'h03;
  localparam logic [7:0] HDR_SET_COEFF  = 8'h24;
  localparam logic [7:0] HDR_GET_CONFIG = 8'h65;
  localparam logic [7:0] HDR_SET_CONFIG = 8'h46;
  localparam logic [7:0] HDR_SET_POS    = 8'h27;
  localparam logic [7:0] HDR_GET_HOME   = 8'h18;
  localparam logic [7:0] HDR_SET_VEL    = 8'h29;
  localparam logic [7:0] HDR_GET_TEMP   = 8'h2A;
  localparam logic [7:0] HDR_GET_MOTION = 8'h1B;
  localparam logic [7:0] HDR_UNKNOWN    = 8'h0F;
  localparam logic [7:0] HDR_RX_ERROR   = 8'h0E;

  localparam logic [2:0] MOTION_MASK    = 3'b101;
  localparam logic [7:0] ACCEL_MAX      = 8'd127;
  localparam logic [15:0] VEL_MAX       = 16'd2000;

  localparam int REPLY_DATA_MAX = 6;

  typedef struct packed {
    logic [7:0]                          hdr;
    logic [2:0]                          len;
    logic [REPLY_DATA_MAX-1:0][7:0]      data;
    logic                                load;
    logic [15:0]                         target;
    logic [15:0]                         coeff;
    logic [15:0]                         btemp;
    logic [15:0]                         bpos;
    logic [15:0]                         vel;
    logic [6:0]                          accel;
    logic                                idle;
  } reply_t;

endpackage

`default_nettype wire

@@ sv/focuser_command_framer_unit.sv @@
// Focuser command framer, top level.
// The slave stream carries received serial bytes together with live sensor
// readings; the master stream carries reply bytes, header first and data
// low byte first, with tlast on the last byte of each reply. Every reply
// byte also carries the motor settings as they stand after the command.
// A frame's header byte holds the data length in its high nibble and the
// command in its low nibble. Bytes that do not complete a frame produce no
// reply. A byte marked as a receive error abandons the frame in progress
// and produces the one-byte reply 0x0E.
// A completed frame's reply record is registered in fcf_frame, then loaded
// into the serializer, which sends its header byte first. The frame logic
// is a single registered pass, so a transaction can be accepted every cycle
// while s_axis_tready is high; a reply holds the serializer until its
// last byte is taken; one more record can wait before s_axis_tready drops.
// When the receiver stalls, the current reply byte holds, and input is
// refused once a reply record is waiting.
// Synchronous reset clears the framing state, the data buffer and all
// motor settings to zero, and drops both valid signals.
// Depends on fcf_pkg, fcf_frame, fcf_reply and the assertion macro header.
`default_nettype none

`include "focuser_command_framer_unit_assert.svh"

module focuser_command_framer_unit #(
  parameter int DATA_BYTES    = 15,
  parameter int IDLE_FLAG_BIT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  // rx_byte[7:0], position[23:8], temperature[39:24], home_switch[40],
  // motion_bits[43:41], zero fill[47:44]
  input  wire logic [47:0]    s_axis_tdata,
  // rx_ok[0]
  input  wire logic           s_axis_tuser,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  // reply_byte[7:0], target_position[23:8], load_position[24],
  // temp_coefficient[40:25], base_temperature[56:41], base_position[72:57],
  // velocity_limit[88:73], accel_limit[95:89], idle_off[96], zero fill[103:97]
  output logic [103:0]        m_axis_tdata,
  output logic                m_axis_tlast
);

  logic             in_fire;
  logic             rep_valid;
  logic             take;
  fcf_pkg::reply_t  rep;

  assign s_axis_tready = !rep_valid || take;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  fcf_frame #(
    .DATA_BYTES    (DATA_BYTES),
    .IDLE_FLAG_BIT (IDLE_FLAG_BIT)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .fire        (in_fire),
    .rx_byte     (s_axis_tdata[7:0]),
    .rx_ok       (s_axis_tuser),
    .position    (s_axis_tdata[23:8]),
    .temperature (s_axis_tdata[39:24]),
    .home_switch (s_axis_tdata[40]),
    .motion_bits (s_axis_tdata[43:41]),
    .take        (take),
    .rep_valid   (rep_valid),
    .rep         (rep)
  );

  fcf_reply u_reply (
    .clk           (clk),
    .rst           (rst),
    .rep_valid     (rep_valid),
    .rep           (rep),
    .take          (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `FCF_ASSERT_NXT(a_err_replies, in_fire && !s_axis_tuser, rep_valid, "receive error gave no reply")
  `FCF_ASSERT_NXT(a_rec_holds, rep_valid && !take, rep_valid && $stable(rep), "waiting reply record changed")
  `FCF_ASSERT_NXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast && !rep_valid, !m_axis_tvalid, "serializer kept running after last byte")

endmodule

`default_nettype wire

@@ sv/fcf_frame.sv @@
// Frame assembly and command execution for the focuser command framer.
// Holds framing state, data buffer and settings; emits one reply record per frame and per receive error.
// Depends on fcf_pkg.
`default_nettype none

module fcf_frame #(
  parameter int DATA_BYTES    = 15,
  parameter int IDLE_FLAG_BIT = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               rx_ok,
  input  wire logic [15:0]        position,
  input  wire logic [15:0]        temperature,
  input  wire logic               home_switch,
  input  wire logic [2:0]         motion_bits,
  input  wire logic               take,
  output logic                    rep_valid,
  output fcf_pkg::reply_t         rep
);

  logic [4:0]                  br, br_next;
  logic [3:0]                  fl, fl_next;
  logic [3:0]                  cmd, cmd_next;
  logic [DATA_BYTES-1:0][7:0]  dbuf, dbuf_next;
  logic [15:0]                 target, target_next;
  logic [15:0]                 coeff, coeff_next;
  logic [15:0]                 btemp, btemp_next;
  logic [15:0]                 bpos, bpos_next;
  logic [15:0]                 vel, vel_next;
  logic [6:0]                  accel, accel_next;
  logic                        idle, idle_next;
  logic                        done;
  logic                        load;
  logic [7:0]                  hdr;
  logic [2:0]                  len;
  logic [15:0]                 word;
  logic [7:0]                  abyte;
  fcf_pkg::reply_t             rep_next;

  always_comb begin
    br_next     = br;
    fl_next     = fl;
    cmd_next    = cmd;
    dbuf_next   = dbuf;
    target_next = target;
    coeff_next  = coeff;
    btemp_next  = btemp;
    bpos_next   = bpos;
    vel_next    = vel;
    accel_next  = accel;
    idle_next   = idle;
    done        = 1'b0;
    load        = 1'b0;
    hdr         = fcf_pkg::HDR_UNKNOWN;
    len         = 3'd0;
    word        = 16'd0;
    abyte       = 8'd0;
    if (fire) begin
      if (!rx_ok) begin
        br_next = 5'd0;
        done    = 1'b1;
        hdr     = fcf_pkg::HDR_RX_ERROR;
      end else begin
        if (br != 5'd0) begin
          for (int i = 0; i < DATA_BYTES; i++) begin
            if (br - 5'd1 == 5'(i)) begin
              dbuf_next[i] = rx_byte;
            end
          end
          br_next = br + 5'd1;
        end else begin
          fl_next  = rx_byte[7:4];
          cmd_next = rx_byte[3:0];
          br_next  = 5'd1;
        end
        if (br_next == {1'b0, fl_next} + 5'd1) begin
          br_next = 5'd0;
          done    = 1'b1;
          word    = {dbuf_next[1], dbuf_next[0]};
          abyte   = dbuf_next[2];
          case (cmd_next)
            fcf_pkg::CMD_GET_POS: begin
              dbuf_next[0] = position[7:0];
              dbuf_next[1] = position[15:8];
              hdr = fcf_pkg::HDR_GET_POS;
              len = 3'd2;
            end
            fcf_pkg::CMD_SET_TARGET: begin
              target_next = word;
              hdr = fcf_pkg::HDR_SET_TARGET;
              len = 3'd2;
            end
            fcf_pkg::CMD_HALT: begin
              target_next = position;
              hdr = fcf_pkg::HDR_HALT;
            end
            fcf_pkg::CMD_SET_COEFF: begin
              btemp_next = temperature;
              bpos_next  = position;
              coeff_next = word;
              hdr = fcf_pkg::HDR_SET_COEFF;
              len = 3'd2;
            end
            fcf_pkg::CMD_GET_CONFIG: begin
              dbuf_next[0] = coeff[7:0];
              dbuf_next[1] = coeff[15:8];
              dbuf_next[2] = idle ? (8'd1 << IDLE_FLAG_BIT) : 8'd0;
              dbuf_next[3] = {1'b0, accel};
              dbuf_next[4] = vel[7:0];
              dbuf_next[5] = vel[15:8];
              hdr = fcf_pkg::HDR_GET_CONFIG;
              len = 3'd6;
            end
            fcf_pkg::CMD_SET_CONFIG: begin
              idle_next = (dbuf_next[3] != 8'd0);
              if (abyte > fcf_pkg::ACCEL_MAX) begin
                accel_next = fcf_pkg::ACCEL_MAX[6:0];
              end else if (abyte == 8'd0) begin
                accel_next = 7'd1;
              end else begin
                accel_next = abyte[6:0];
              end
              if (word > fcf_pkg::VEL_MAX) begin
                vel_next = fcf_pkg::VEL_MAX;
              end else if (word == 16'd0) begin
                vel_next = 16'd1;
              end else begin
                vel_next = word;
              end
              hdr = fcf_pkg::HDR_SET_CONFIG;
              len = 3'd4;
            end
            fcf_pkg::CMD_SET_POS: begin
              target_next = word;
              load = 1'b1;
              hdr = fcf_pkg::HDR_SET_POS;
              len = 3'd2;
            end
            fcf_pkg::CMD_GET_HOME: begin
              dbuf_next[0] = {7'd0, home_switch};
              hdr = fcf_pkg::HDR_GET_HOME;
              len = 3'd1;
            end
            fcf_pkg::CMD_SET_VEL: begin
              vel_next = word;
              hdr = fcf_pkg::HDR_SET_VEL;
              len = 3'd2;
            end
            fcf_pkg::CMD_GET_TEMP: begin
              dbuf_next[0] = temperature[7:0];
              dbuf_next[1] = temperature[15:8];
              hdr = fcf_pkg::HDR_GET_TEMP;
              len = 3'd2;
            end
            fcf_pkg::CMD_GET_MOTION: begin
              dbuf_next[0] = {5'd0, motion_bits & fcf_pkg::MOTION_MASK};
              hdr = fcf_pkg::HDR_GET_MOTION;
              len = 3'd1;
            end
            default: begin
              hdr = fcf_pkg::HDR_UNKNOWN;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    rep_next.hdr  = hdr;
    rep_next.len  = len;
    for (int i = 0; i < fcf_pkg::REPLY_DATA_MAX; i++) begin
      rep_next.data[i] = dbuf_next[i];
    end
    rep_next.load   = load;
    rep_next.target = target_next;
    rep_next.coeff  = coeff_next;
    rep_next.btemp  = btemp_next;
    rep_next.bpos   = bpos_next;
    rep_next.vel    = vel_next;
    rep_next.accel  = accel_next;
    rep_next.idle   = idle_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      br        <= 5'd0;
      fl        <= 4'd0;
      cmd       <= 4'd0;
      dbuf      <= '0;
      target    <= 16'd0;
      coeff     <= 16'd0;
      btemp     <= 16'd0;
      bpos      <= 16'd0;
      vel       <= 16'd0;
      accel     <= 7'd0;
      idle      <= 1'b0;
      rep_valid <= 1'b0;
    end else begin
      br     <= br_next;
      fl     <= fl_next;
      cmd    <= cmd_next;
      dbuf   <= dbuf_next;
      target <= target_next;
      coeff  <= coeff_next;
      btemp  <= btemp_next;
      bpos   <= bpos_next;
      vel    <= vel_next;
      accel  <= accel_next;
      idle   <= idle_next;
      if (done) begin
        rep_valid <= 1'b1;
      end else if (take) begin
        rep_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rep <= rep_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/fcf_reply.sv @@
// Reply serializer for the focuser command framer.
// Takes a reply record and sends its header and data bytes one per transaction.
// Depends on fcf_pkg.
`default_nettype none

module fcf_reply (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rep_valid,
  input  wire fcf_pkg::reply_t  rep,
  output logic                  take,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [103:0]          m_axis_tdata,
  output logic                  m_axis_tlast
);

  logic             active;
  logic [2:0]       cnt;
  fcf_pkg::reply_t  cur;
  logic             fire;
  logic             last;
  logic [7:0]       rbyte;

  assign fire  = active && m_axis_tready;
  assign last  = (cnt == cur.len);
  assign take  = rep_valid && (!active || (fire && last));

  always_comb begin
    case (cnt)
      3'd0:    rbyte = cur.hdr;
      3'd1:    rbyte = cur.data[0];
      3'd2:    rbyte = cur.data[1];
      3'd3:    rbyte = cur.data[2];
      3'd4:    rbyte = cur.data[3];
      3'd5:    rbyte = cur.data[4];
      3'd6:    rbyte = cur.data[5];
      default: rbyte = cur.hdr;
    endcase
  end

  assign m_axis_tvalid = active;
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {7'd0, cur.idle, cur.accel, cur.vel, cur.bpos, cur.btemp,
                          cur.coeff, cur.load, cur.target, rbyte};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= 3'd0;
    end else if (take) begin
      active <= 1'b1;
      cnt    <= 3'd0;
    end else if (fire) begin
      if (last) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= rep;
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for focuser_command_framer_unit.
// Sends serial byte frames with live sensor readings and checks every reply byte
// against a cycle-free prediction of the framer; depends only on fcf_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_BYTES    = 15;
  localparam int IDLE_FLAG_BIT = 0;
  localparam int RANDOM_BYTES  = 130;
  localparam int HOLD_AT       = 100;
  localparam int HOLD_LEN      = 200;
  localparam int END_CYCLES    = 20;
  localparam int CYCLE_LIMIT   = 200000;

  localparam logic [3:0] CMD_NONE        = 4'h0;
  localparam logic [3:0] CMD_SPARE_FIRST = 4'hC;
  localparam logic [3:0] CMD_SPARE_LAST  = 4'hF;

  typedef struct {
    logic [7:0]  data;
    logic        ok;
    logic [15:0] pos;
    logic [15:0] temp;
    logic        home;
    logic [2:0]  motion;
    int          gap;
    bit          drain_first;
  } rx_item_t;

  typedef struct {
    logic [7:0]  byte_val;
    logic        last;
    logic [15:0] target;
    logic        load;
    logic [15:0] coeff;
    logic [15:0] btemp;
    logic [15:0] bpos;
    logic [15:0] vel;
    logic [6:0]  accel;
    logic        idle;
  } reply_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;

  focuser_command_framer_unit #(
    .DATA_BYTES    (DATA_BYTES),
    .IDLE_FLAG_BIT (IDLE_FLAG_BIT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_item_t    rx_stream[$];
  reply_beat_t replies_due[$];
  rx_item_t    cur_byte;

  logic [4:0]  frame_count = '0;
  logic [3:0]  frame_len = '0;
  logic [3:0]  frame_cmd = '0;
  logic [7:0]  rx_buf[DATA_BYTES];
  logic [15:0] target_q = '0;
  logic [15:0] coeff_q = '0;
  logic [15:0] base_temp_q = '0;
  logic [15:0] base_pos_q = '0;
  logic [15:0] vel_q = '0;
  logic [6:0]  accel_q = '0;
  logic        idle_q = 1'b0;

  int  bytes_accepted = 0;
  int  beats_checked = 0;
  int  mismatches = 0;
  int  rx_errors = 0;
  int  cycle_count = 0;
  int  quiet_tx = 0;
  int  rx_quiet = 0;
  int  rx_wait = 0;
  bit  cmds_run[16];
  bit  offer;
  bit  take;
  logic rx_hold = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cycles = 0;

  initial begin
    for (int i = 0; i < DATA_BYTES; i++) rx_buf[i] = '0;
  end

  function automatic void queue_reply(logic [7:0] hdr, int n, logic load);
    reply_beat_t r;
    for (int k = 0; k <= n; k++) begin
      r.byte_val = (k == 0) ? hdr : rx_buf[k - 1];
      r.last     = (k == n);
      r.target   = target_q;
      r.load     = load;
      r.coeff    = coeff_q;
      r.btemp    = base_temp_q;
      r.bpos     = base_pos_q;
      r.vel      = vel_q;
      r.accel    = accel_q;
      r.idle     = idle_q;
      replies_due.push_back(r);
    end
  endfunction

  function automatic void apply_rx_byte(rx_item_t it);
    logic [15:0] w;
    logic [7:0]  a;
    if (!it.ok) begin
      frame_count = '0;
      rx_errors++;
      queue_reply(fcf_pkg::HDR_RX_ERROR, 0, 1'b0);
      return;
    end
    if (frame_count != 0) begin
      if (int'(frame_count) - 1 < DATA_BYTES) rx_buf[frame_count - 5'd1] = it.data;
      frame_count = frame_count + 5'd1;
    end else begin
      frame_len   = it.data[7:4];
      frame_cmd   = it.data[3:0];
      frame_count = 5'd1;
    end
    if (frame_count != {1'b0, frame_len} + 5'd1) return;
    frame_count = '0;
    cmds_run[frame_cmd] = 1'b1;
    w = {rx_buf[1], rx_buf[0]};
    case (frame_cmd)
      fcf_pkg::CMD_GET_POS: begin
        {rx_buf[1], rx_buf[0]} = it.pos;
        queue_reply(fcf_pkg::HDR_GET_POS, 2, 1'b0);
      end
      fcf_pkg::CMD_SET_TARGET: begin
        target_q = w;
        queue_reply(fcf_pkg::HDR_SET_TARGET, 2, 1'b0);
      end
      fcf_pkg::CMD_HALT: begin
        target_q = it.pos;
        queue_reply(fcf_pkg::HDR_HALT, 0, 1'b0);
      end
      fcf_pkg::CMD_SET_COEFF: begin
        base_temp_q = it.temp;
        base_pos_q  = it.pos;
        coeff_q     = w;
        queue_reply(fcf_pkg::HDR_SET_COEFF, 2, 1'b0);
      end
      fcf_pkg::CMD_GET_CONFIG: begin
        {rx_buf[1], rx_buf[0]} = coeff_q;
        rx_buf[2] = idle_q ? 8'(1 << IDLE_FLAG_BIT) : 8'h00;
        rx_buf[3] = {1'b0, accel_q};
        {rx_buf[5], rx_buf[4]} = vel_q;
        queue_reply(fcf_pkg::HDR_GET_CONFIG, 6, 1'b0);
      end
      fcf_pkg::CMD_SET_CONFIG: begin
        a = rx_buf[2];
        idle_q = (rx_buf[3] != 8'h00);
        if (a > fcf_pkg::ACCEL_MAX) a = fcf_pkg::ACCEL_MAX;
        if (a == 8'h00) a = 8'h01;
        accel_q = a[6:0];
        if (w > fcf_pkg::VEL_MAX) w = fcf_pkg::VEL_MAX;
        if (w == 16'h0000) w = 16'h0001;
        vel_q = w;
        queue_reply(fcf_pkg::HDR_SET_CONFIG, 4, 1'b0);
      end
      fcf_pkg::CMD_SET_POS: begin
        target_q = w;
        queue_reply(fcf_pkg::HDR_SET_POS, 2, 1'b1);
      end
      fcf_pkg::CMD_GET_HOME: begin
        rx_buf[0] = {7'b0, it.home};
        queue_reply(fcf_pkg::HDR_GET_HOME, 1, 1'b0);
      end
      fcf_pkg::CMD_SET_VEL: begin
        vel_q = w;
        queue_reply(fcf_pkg::HDR_SET_VEL, 2, 1'b0);
      end
      fcf_pkg::CMD_GET_TEMP: begin
        {rx_buf[1], rx_buf[0]} = it.temp;
        queue_reply(fcf_pkg::HDR_GET_TEMP, 2, 1'b0);
      end
      fcf_pkg::CMD_GET_MOTION: begin
        rx_buf[0] = {5'b0, it.motion & fcf_pkg::MOTION_MASK};
        queue_reply(fcf_pkg::HDR_GET_MOTION, 1, 1'b0);
      end
      default: queue_reply(fcf_pkg::HDR_UNKNOWN, 0, 1'b0);
    endcase
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on reply byte %0d, %s: expected %h, got %h",
                 beats_checked, what, want, got);
    end
  endfunction

  function automatic void check_reply_beat();
    reply_beat_t w;
    if (replies_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected reply byte %h with nothing outstanding", m_axis_tdata[7:0]);
      return;
    end
    w = replies_due.pop_front();
    beats_checked++;
    check_field("reply_byte", w.byte_val, m_axis_tdata[7:0]);
    check_field("reply_last", w.last, m_axis_tlast);
    check_field("target_position", w.target, m_axis_tdata[23:8]);
    check_field("load_position", w.load, m_axis_tdata[24]);
    check_field("temp_coefficient", w.coeff, m_axis_tdata[40:25]);
    check_field("base_temperature", w.btemp, m_axis_tdata[56:41]);
    check_field("base_position", w.bpos, m_axis_tdata[72:57]);
    check_field("velocity_limit", w.vel, m_axis_tdata[88:73]);
    check_field("accel_limit", w.accel, m_axis_tdata[95:89]);
    check_field("idle_off", w.idle, m_axis_tdata[96]);
  endfunction

  function automatic int next_gap();
    if (quiet_tx > 0) begin
      quiet_tx--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_tx = $urandom_range(10, 30);
    return $urandom_range(0, 9);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic ok);
    rx_item_t it;
    it.data        = b;
    it.ok          = ok;
    it.pos         = 16'($urandom);
    it.temp        = 16'($urandom);
    it.home        = 1'($urandom);
    it.motion      = 3'($urandom_range(0, 5));
    it.gap         = next_gap();
    it.drain_first = 1'b0;
    rx_stream.push_back(it);
  endfunction

  function automatic int data_len_for(logic [3:0] cmd);
    case (cmd)
      fcf_pkg::CMD_SET_TARGET, fcf_pkg::CMD_SET_COEFF,
      fcf_pkg::CMD_SET_POS, fcf_pkg::CMD_SET_VEL: return 2;
      fcf_pkg::CMD_SET_CONFIG: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] pick_velocity();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return fcf_pkg::VEL_MAX - 16'd1;
      3: return fcf_pkg::VEL_MAX;
      4: return fcf_pkg::VEL_MAX + 16'd1;
      5: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_accel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return fcf_pkg::ACCEL_MAX;
      3: return fcf_pkg::ACCEL_MAX + 8'd1;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_random_frame();
    logic [3:0] cmd;
    logic [7:0] d[16];
    logic [15:0] v;
    int len;
    int cut;
    if ($urandom_range(0, 6) == 0) cmd = 4'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    else if ($urandom_range(0, 15) == 0) cmd = CMD_NONE;
    else cmd = 4'($urandom_range(fcf_pkg::CMD_GET_POS, fcf_pkg::CMD_GET_MOTION));
    len = data_len_for(cmd);
    if ($urandom_range(0, 7) == 0) len = $urandom_range(0, 3);
    else if ($urandom_range(0, 19) == 0) len = $urandom_range(4, 15);
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(0, 7))
        0: d[i] = 8'h00;
        1: d[i] = 8'hFF;
        default: d[i] = 8'($urandom);
      endcase
    end
    if (cmd == fcf_pkg::CMD_SET_CONFIG) begin
      v = pick_velocity();
      d[0] = v[7:0];
      d[1] = v[15:8];
      d[2] = pick_accel();
      d[3] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
    end
    cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, len) : -1;
    add_byte({4'(len), cmd}, 1'b1);
    for (int i = 0; i < len; i++) begin
      if (i == cut) break;
      add_byte(d[i], 1'b1);
    end
    if (cut >= 0) add_byte(8'($urandom), 1'b0);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_rx_byte(cur_byte);
        bytes_accepted <= bytes_accepted + 1;
        offer = 1'b0;
      end
      if (!offer && rx_stream.size() > 0) begin
        if (!(rx_stream[0].drain_first && replies_due.size() != 0)) begin
          if (rx_stream[0].gap > 0) begin
            rx_stream[0].gap = rx_stream[0].gap - 1;
          end else begin
            cur_byte = rx_stream.pop_front();
            offer = 1'b1;
          end
        end
      end
      s_axis_tvalid <= offer;
      s_axis_tdata  <= {4'b0, cur_byte.motion, cur_byte.home, cur_byte.temp,
                        cur_byte.pos, cur_byte.data};
      s_axis_tuser  <= cur_byte.ok;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 1'b0;
    end else if (!hold_done && !rx_hold && bytes_accepted >= HOLD_AT) begin
      rx_hold <= 1'b1;
      hold_cycles <= 0;
    end else if (rx_hold) begin
      if (hold_cycles == HOLD_LEN) begin
        rx_hold <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cycles <= hold_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      take = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        check_reply_beat();
        if (rx_quiet > 0) begin
          rx_quiet--;
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, 9);
          if ($urandom_range(0, 15) == 0) rx_quiet = $urandom_range(10, 30);
        end
        take = (rx_wait == 0);
      end else if (!take) begin
        if (rx_wait > 0) rx_wait--;
        take = (rx_wait == 0);
      end
      m_axis_tready <= take && !rx_hold;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout with %0d reply bytes still outstanding", replies_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int ncmds;
    bit mid_drain;
    ncmds = 0;
    mid_drain = 1'b0;

    add_byte({4'd0, fcf_pkg::CMD_GET_POS}, 1'b1);
    rx_stream[$].pos = 16'h8000;
    add_byte({4'd0, fcf_pkg::CMD_HALT}, 1'b1);
    rx_stream[$].pos = 16'h7FFF;
    add_byte({4'd2, fcf_pkg::CMD_SET_COEFF}, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'h80, 1'b1);
    rx_stream[$].temp = 16'h8000;
    add_byte({4'd4, fcf_pkg::CMD_SET_CONFIG}, 1'b1);
    repeat (4) add_byte(8'h00, 1'b1);
    add_byte({4'd4, fcf_pkg::CMD_SET_CONFIG}, 1'b1);
    repeat (3) add_byte(8'hFF, 1'b1);
    add_byte(8'h01, 1'b1);
    add_byte({4'd0, fcf_pkg::CMD_GET_CONFIG}, 1'b1);
    add_byte({4'd2, fcf_pkg::CMD_SET_POS}, 1'b1);
    add_byte(8'h34, 1'b1);
    add_byte(8'h12, 1'b1);
    add_byte({4'd0, fcf_pkg::CMD_GET_HOME}, 1'b1);
    rx_stream[$].home = 1'b1;
    add_byte({4'd2, fcf_pkg::CMD_SET_VEL}, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte({4'd0, fcf_pkg::CMD_GET_TEMP}, 1'b1);
    rx_stream[$].temp = 16'h7FFF;
    add_byte({4'd0, fcf_pkg::CMD_GET_MOTION}, 1'b1);
    rx_stream[$].motion = 3'd5;
    add_byte({4'd0, CMD_NONE}, 1'b1);
    add_byte({4'd2, fcf_pkg::CMD_SET_TARGET}, 1'b1);
    add_byte(8'h5A, 1'b1);
    add_byte(8'hA5, 1'b0);
    add_byte({4'd0, fcf_pkg::CMD_SET_TARGET}, 1'b1);
    add_byte(8'h00, 1'b0);

    add_byte({4'd2, fcf_pkg::CMD_SET_TARGET}, 1'b1);
    rx_stream[$].drain_first = 1'b1;
    add_byte(8'($urandom), 1'b1);
    add_byte(8'($urandom), 1'b1);
    while (rx_stream.size() < RANDOM_BYTES + 30) begin
      if (!mid_drain && rx_stream.size() > 100) begin
        mid_drain = 1'b1;
        add_random_frame();
        rx_stream[$].drain_first = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        add_byte(8'($urandom), 1'b0);
      end else begin
        add_random_frame();
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (rx_stream.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
      @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    for (int c = 0; c < 16; c++) ncmds += cmds_run[c];
    $display("Sent %0d serial bytes (%0d receive errors), checked %0d reply bytes;",
             bytes_accepted, rx_errors, beats_checked);
    $display("%0d of 16 command codes completed, including a long reply backpressure stall.",
             ncmds);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/fcf_pkg.sv
sv/fcf_frame.sv
sv/fcf_reply.sv
sv/focuser_command_framer_unit.sv
tb/testbench.sv
